FILE: rtl/hbp_pkg.sv
// Shared constants, types and helper functions for the HUB75 bit-plane packer.
// Used by hbp_front, hbp_back and hub75_bitplane_packer_core; no dependencies.
package hbp_pkg;

  localparam int PANEL_WIDTH     = 64;
  localparam int SCAN_ROWS       = 16;
  localparam int ROW_FIELD_SHIFT = 6;
  localparam int PLANES          = 8;

  localparam int PAIRS      = PANEL_WIDTH / 2;
  localparam int PAIR_W     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int ROW_W      = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
  localparam int PLANE_W    = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int BANK_DEPTH = SCAN_ROWS * PAIRS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int NUM_BANKS  = 4;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW    = 2;

  localparam logic [4:0] BRIGHT_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'b01,
    CMD_FETCH = 2'b10
  } hbp_cmd_e;

  typedef struct packed {
    hbp_cmd_e             kind;
    logic                 lower;
    logic                 odd;
    logic [BANK_AW-1:0]   addr;
    logic [23:0]          color;
  } hbp_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  plane;
    logic [3:0]  row;
    logic [4:0]  pair;
    logic        last;
  } hbp_res_t;

  function automatic logic [2:0] color_bits(logic [23:0] pix, logic [PLANE_W-1:0] plane);
    logic [4:0] p;
    p = 5'(plane);
    return {pix[p], pix[p + 5'd8], pix[p + 5'd16]};
  endfunction

  function automatic logic [31:0] split_value(logic [9:0] v);
    return {v[4:0], 27'd0} | (32'(v[9:5]) << 11);
  endfunction

endpackage

FILE: rtl/hbp_front.sv
// Front end of the packer: classifies incoming items and queues the commands.
// Out-of-range pixel writes are dropped here. Depends on hbp_pkg.
module hbp_front import hbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [4:0]  pixel_row_i,
  input  logic [5:0]  pixel_column_i,
  input  logic [23:0] color_i,
  input  logic        clearing_i,
  output logic        cmd_valid_o,
  output hbp_cmd_t    cmd_o,
  input  logic        cmd_pop_i
);

  hbp_cmd_t             q_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CMDQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CMDQ_AW:0]     count_q, count_d;
  logic                 in_range;
  logic                 lower;
  logic [4:0]           half_row;
  logic                 enqueue;
  hbp_cmd_t             cmd_in;

  always_comb begin
    in_range = (int'(pixel_row_i) < 2 * SCAN_ROWS) && (int'(pixel_column_i) < PANEL_WIDTH);
    lower    = int'(pixel_row_i) >= SCAN_ROWS;
    half_row = lower ? (pixel_row_i - 5'(SCAN_ROWS)) : pixel_row_i;
    cmd_in.kind  = op_i ? CMD_FETCH : CMD_WRITE;
    cmd_in.lower = lower;
    cmd_in.odd   = pixel_column_i[0];
    cmd_in.addr  = BANK_AW'(half_row[ROW_W-1:0]) * BANK_AW'(PAIRS)
                 + BANK_AW'(pixel_column_i >> 1);
    cmd_in.color = color_i;
  end

  assign full        = clearing_i || (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign enqueue     = push && !full && (op_i || in_range);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = enqueue ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (CMDQ_AW+1)'(enqueue) - (CMDQ_AW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enqueue) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/hbp_back.sv
// Back end of the packer: pixel store banks, scan counters, word assembly and
// the result queue. Clears the store after reset. Depends on hbp_pkg.
module hbp_back import hbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  hbp_cmd_t    cmd_i,
  output logic        cmd_pop_o,
  output logic        clearing_o,
  input  logic [4:0]  brightness_i,
  output logic        empty,
  input  logic        pop,
  output hbp_res_t    res_o
);

  logic                 clr_q, clr_d;
  logic [BANK_AW-1:0]   clr_addr_q, clr_addr_d;
  logic [PLANE_W-1:0]   plane_q, plane_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [PAIR_W-1:0]    pair_q, pair_d;
  logic                 credit_ok;
  logic                 fetch_go;
  logic                 write_go;
  logic [BANK_AW-1:0]   scan_addr;
  logic                 pos_last_pair;
  logic                 pos_last_row;
  logic                 pos_last_plane;

  logic [23:0]          rd_q [NUM_BANKS];
  logic                 b_valid_q;
  logic [PLANE_W-1:0]   b_plane_q;
  logic [ROW_W-1:0]     b_row_q;
  logic [PAIR_W-1:0]    b_pair_q;
  logic                 b_last_q;

  hbp_res_t             res_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0]   res_wr_q, res_rd_q;
  logic [RESQ_AW:0]     res_count_q, res_count_d;
  logic                 res_pop;
  hbp_res_t             res_new;

  logic [15:0]          half0, half1;
  logic [4:0]           sel;
  logic [9:0]           delay_val;
  logic [9:0]           bright_val;
  logic [31:0]          word;

  assign clearing_o     = clr_q;
  assign credit_ok      = (res_count_q + (RESQ_AW+1)'(b_valid_q)) < (RESQ_AW+1)'(RESQ_DEPTH);
  assign write_go       = !clr_q && cmd_valid_i && (cmd_i.kind == CMD_WRITE);
  assign fetch_go       = !clr_q && cmd_valid_i && (cmd_i.kind == CMD_FETCH) && credit_ok;
  assign cmd_pop_o      = write_go || fetch_go;
  assign scan_addr      = BANK_AW'(row_q) * BANK_AW'(PAIRS) + BANK_AW'(pair_q);
  assign pos_last_pair  = pair_q == PAIR_W'(PAIRS - 1);
  assign pos_last_row   = row_q == ROW_W'(SCAN_ROWS - 1);
  assign pos_last_plane = plane_q == PLANE_W'(PLANES - 1);

  always_comb begin
    clr_d      = clr_q && (clr_addr_q != BANK_AW'(BANK_DEPTH - 1));
    clr_addr_d = clr_q ? clr_addr_q + 1'b1 : clr_addr_q;
    plane_d    = plane_q;
    row_d      = row_q;
    pair_d     = pair_q;
    if (fetch_go) begin
      pair_d = pos_last_pair ? '0 : pair_q + 1'b1;
      if (pos_last_pair) begin
        row_d = pos_last_row ? '0 : row_q + 1'b1;
        if (pos_last_row) begin
          plane_d = pos_last_plane ? '0 : plane_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      plane_q    <= '0;
      row_q      <= '0;
      pair_q     <= '0;
      b_valid_q  <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      plane_q    <= plane_d;
      row_q      <= row_d;
      pair_q     <= pair_d;
      b_valid_q  <= fetch_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_go) begin
      b_plane_q <= plane_q;
      b_row_q   <= row_q;
      b_pair_q  <= pair_q;
      b_last_q  <= pos_last_plane && pos_last_row && pos_last_pair;
    end
  end

  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    localparam bit LOWER = (gb / 2) == 1;
    localparam bit ODD   = (gb % 2) == 1;
    logic [23:0]        mem [BANK_DEPTH];
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [23:0]        wdata;

    assign we    = clr_q || (write_go && (cmd_i.lower == LOWER) && (cmd_i.odd == ODD));
    assign waddr = clr_q ? clr_addr_q : cmd_i.addr;
    assign wdata = clr_q ? 24'd0 : cmd_i.color;

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (fetch_go) begin
        rd_q[gb] <= mem[scan_addr];
      end
    end
  end

  always_comb begin
    half0 = 16'({color_bits(rd_q[2], b_plane_q), color_bits(rd_q[0], b_plane_q)});
    half1 = 16'({color_bits(rd_q[3], b_plane_q), color_bits(rd_q[1], b_plane_q)});
    sel   = (b_pair_q == PAIR_W'(PAIRS - 1)) ? 5'(b_row_q) : 5'(b_row_q) - 5'd1;
    delay_val  = 10'((11'd1 << b_plane_q) - 11'd1);
    bright_val = 10'(BRIGHT_MAX - brightness_i);
    word = {half1, half0} | (32'(sel) << ROW_FIELD_SHIFT)
         | (32'(sel) << (ROW_FIELD_SHIFT + 16));
    if (b_pair_q == PAIR_W'(PAIRS - 2)) begin
      word = word | split_value(delay_val);
    end
    if (b_pair_q == PAIR_W'(PAIRS - 1)) begin
      word = word | split_value(bright_val);
    end
    res_new.word  = word;
    res_new.plane = 3'(b_plane_q);
    res_new.row   = 4'(b_row_q);
    res_new.pair  = 5'(b_pair_q);
    res_new.last  = b_last_q;
  end

  assign empty       = res_count_q == '0;
  assign res_pop     = pop && !empty;
  assign res_o       = res_q[res_rd_q];
  assign res_count_d = res_count_q + (RESQ_AW+1)'(b_valid_q) - (RESQ_AW+1)'(res_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q    <= '0;
      res_rd_q    <= '0;
      res_count_q <= '0;
    end else begin
      res_wr_q    <= b_valid_q ? res_wr_q + 1'b1 : res_wr_q;
      res_rd_q    <= res_pop ? res_rd_q + 1'b1 : res_rd_q;
      res_count_q <= res_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      res_q[res_wr_q] <= res_new;
    end
  end

endmodule

FILE: rtl/hub75_bitplane_packer_core.sv
// Top level of the HUB75 bit-plane packer: brightness register, front and back.
// Throughput is one item per cycle while full is low; every transfer is registered
// in the command queue, and a fetch word also in the bank read and result registers.
// After reset all BANK_DEPTH (512) addresses of each bank are cleared with full held high.
// Reset sets brightness to 31 and the scan position to plane 0, row 0, pair 0.
// Depends on hbp_pkg, hbp_front and hbp_back.
module hub75_bitplane_packer_core import hbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [4:0]  pixel_row_i,
  input  logic [5:0]  pixel_column_i,
  input  logic [23:0] color_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] frame_word_o,
  output logic [2:0]  plane_index_o,
  output logic [3:0]  scan_row_o,
  output logic [4:0]  column_pair_o,
  output logic        last_of_frame_o,
  input  logic        brightness_we_i,
  input  logic [4:0]  brightness_i
);

  logic [4:0] bright_q;
  logic       clearing;
  logic       cmd_valid;
  logic       cmd_pop;
  hbp_cmd_t   cmd;
  hbp_res_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_MAX;
    end else if (brightness_we_i) begin
      bright_q <= brightness_i;
    end
  end

  hbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .color_i        (color_i),
    .clearing_i     (clearing),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  hbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .clearing_o   (clearing),
    .brightness_i (bright_q),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign frame_word_o    = res.word;
  assign plane_index_o   = res.plane;
  assign scan_row_o      = res.row;
  assign column_pair_o   = res.pair;
  assign last_of_frame_o = res.last;

endmodule
